FILE: src/text_mode_console_writer_core_assert.svh
// Assertion macros used by the console writer back end.
`ifndef TEXT_MODE_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_CORE_ASSERT_SVH

// Condition holds in the same cycle as the antecedent.
`define TMCW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the cycle after the antecedent.
`define TMCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tmcw_pkg.sv
// Package with the types, constants and palette function of the console writer.
`timescale 1ns / 1ps
`default_nettype none
package tmcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NUL   = 8'd0;

    localparam logic [3:0] FG_RESET = 4'd7;
    localparam logic [3:0] BG_RESET = 4'd0;
    localparam logic [3:0] CLR_FG   = 4'd1;
    localparam logic [3:0] CLR_BG   = 4'd0;

    localparam logic [7:0] SGR_FG_LO  = 8'd30;
    localparam logic [7:0] SGR_FG_HI  = 8'd37;
    localparam logic [7:0] SGR_BG_LO  = 8'd40;
    localparam logic [7:0] SGR_BG_HI  = 8'd47;
    localparam logic [7:0] SGR_FGB_LO = 8'd90;
    localparam logic [7:0] SGR_FGB_HI = 8'd97;
    localparam logic [7:0] SGR_BGB_LO = 8'd100;
    localparam logic [7:0] SGR_BGB_HI = 8'd107;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_ANSI  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        OP_CHAR,
        OP_LF,
        OP_CR,
        OP_FG,
        OP_BG,
        OP_NONE,
        OP_READ,
        OP_READ_ZERO,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_byte;
        logic [7:0] ansi_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
        logic [7:0] cell_char;
        logic [3:0] cell_fg;
        logic [3:0] cell_bg;
    } t_out;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [3:0] colour;
        logic [4:0] row;
        logic [6:0] col;
    } t_cmd;

    // Maps an SGR colour index (bright bit on top) to the VGA palette index.
    function automatic logic [3:0] sgr_to_vga(input logic [3:0] idx);
        logic [3:0] vga;
        case (idx)
            4'd0:    vga = 4'd0;
            4'd1:    vga = 4'd4;
            4'd2:    vga = 4'd2;
            4'd3:    vga = 4'd6;
            4'd4:    vga = 4'd1;
            4'd5:    vga = 4'd5;
            4'd6:    vga = 4'd3;
            4'd7:    vga = 4'd7;
            4'd8:    vga = 4'd8;
            4'd9:    vga = 4'd12;
            4'd10:   vga = 4'd10;
            4'd11:   vga = 4'd14;
            4'd12:   vga = 4'd9;
            4'd13:   vga = 4'd13;
            4'd14:   vga = 4'd11;
            4'd15:   vga = 4'd15;
            default: vga = 4'd0;
        endcase
        return vga;
    endfunction

endpackage
`default_nettype wire

FILE: src/tmcw_front.sv
// Front end: classifies an incoming beat into a command for the back end.
`timescale 1ns / 1ps
`default_nettype none
module tmcw_front #(
    parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
    input  tmcw_pkg::t_in  i_in,
    output tmcw_pkg::t_cmd o_cmd
);

    localparam logic [7:0] COL_LIM = 8'(COLUMNS);
    localparam logic [5:0] ROW_LIM = 6'(ROWS);

    logic [7:0] off_fg;
    logic [7:0] off_bg;
    logic [7:0] off_fgb;
    logic [7:0] off_bgb;

    assign off_fg  = i_in.ansi_code - tmcw_pkg::SGR_FG_LO;
    assign off_bg  = i_in.ansi_code - tmcw_pkg::SGR_BG_LO;
    assign off_fgb = i_in.ansi_code - tmcw_pkg::SGR_FGB_LO;
    assign off_bgb = i_in.ansi_code - tmcw_pkg::SGR_BGB_LO;

    always_comb begin
        o_cmd.op     = tmcw_pkg::OP_NONE;
        o_cmd.data   = i_in.char_byte;
        o_cmd.colour = 4'd0;
        o_cmd.row    = i_in.read_row;
        o_cmd.col    = i_in.read_col;
        case (tmcw_pkg::t_action'(i_in.action))
            tmcw_pkg::ACT_WRITE: begin
                if (i_in.char_byte == tmcw_pkg::CH_LF) begin
                    o_cmd.op = tmcw_pkg::OP_LF;
                end else if (i_in.char_byte == tmcw_pkg::CH_CR) begin
                    o_cmd.op = tmcw_pkg::OP_CR;
                end else begin
                    o_cmd.op = tmcw_pkg::OP_CHAR;
                end
            end
            tmcw_pkg::ACT_ANSI: begin
                if (i_in.ansi_code >= tmcw_pkg::SGR_FG_LO
                        && i_in.ansi_code <= tmcw_pkg::SGR_FG_HI) begin
                    o_cmd.op     = tmcw_pkg::OP_FG;
                    o_cmd.colour = tmcw_pkg::sgr_to_vga({1'b0, off_fg[2:0]});
                end else if (i_in.ansi_code >= tmcw_pkg::SGR_BG_LO
                        && i_in.ansi_code <= tmcw_pkg::SGR_BG_HI) begin
                    o_cmd.op     = tmcw_pkg::OP_BG;
                    o_cmd.colour = tmcw_pkg::sgr_to_vga({1'b0, off_bg[2:0]});
                end else if (i_in.ansi_code >= tmcw_pkg::SGR_FGB_LO
                        && i_in.ansi_code <= tmcw_pkg::SGR_FGB_HI) begin
                    o_cmd.op     = tmcw_pkg::OP_FG;
                    o_cmd.colour = tmcw_pkg::sgr_to_vga({1'b1, off_fgb[2:0]});
                end else if (i_in.ansi_code >= tmcw_pkg::SGR_BGB_LO
                        && i_in.ansi_code <= tmcw_pkg::SGR_BGB_HI) begin
                    o_cmd.op     = tmcw_pkg::OP_BG;
                    o_cmd.colour = tmcw_pkg::sgr_to_vga({1'b1, off_bgb[2:0]});
                end
            end
            tmcw_pkg::ACT_READ: begin
                if (6'(i_in.read_row) < ROW_LIM && 8'(i_in.read_col) < COL_LIM) begin
                    o_cmd.op = tmcw_pkg::OP_READ;
                end else begin
                    o_cmd.op = tmcw_pkg::OP_READ_ZERO;
                end
            end
            tmcw_pkg::ACT_CLEAR: begin
                o_cmd.op = tmcw_pkg::OP_CLEAR;
            end
            default: begin
                o_cmd.op = tmcw_pkg::OP_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/tmcw_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module tmcw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tmcw_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output tmcw_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    localparam logic [tmcw_pkg::QAW:0] Q_FULL = (tmcw_pkg::QAW + 1)'(tmcw_pkg::QDEPTH);

    tmcw_pkg::t_cmd               r_slots [tmcw_pkg::QDEPTH];
    logic [tmcw_pkg::QAW-1:0]     r_wr_ptr;
    logic [tmcw_pkg::QAW-1:0]     r_rd_ptr;
    logic [tmcw_pkg::QAW:0]       r_count;

    assign o_full  = (r_count == Q_FULL);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + {{tmcw_pkg::QAW{1'b0}}, i_push}
                               - {{tmcw_pkg::QAW{1'b0}}, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: src/tmcw_back.sv
// Back end: cursor, colours, cell store, scroll and clear walks, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "text_mode_console_writer_core_assert.svh"
module tmcw_back #(
    parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tmcw_pkg::t_cmd i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tmcw_pkg::t_out o_out
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0] ROW_SPAN   = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_COPY  = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] FIRST_FILL = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [7:0]    COL_LIM    = 8'(COLUMNS);
    localparam logic [5:0]    ROW_LIM    = 6'(ROWS);
    localparam logic [4:0]    LAST_ROW   = 5'(ROWS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_DRAIN,
        S_FILL,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [6:0]      r_cur_x, n_cur_x;
    logic [4:0]      r_cur_y, n_cur_y;
    logic [3:0]      r_fg, n_fg;
    logic [3:0]      r_bg, n_bg;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_waddr, n_waddr;
    logic            r_scr_flag, n_scr_flag;
    logic            r_cell_flag, n_cell_flag;
    logic            r_out_valid, n_out_valid;
    tmcw_pkg::t_out  r_out, n_out;

    logic [15:0]     r_cells [CELLS];
    logic [15:0]     r_rdata;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [15:0]     mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    logic [AW-1:0]   cur_addr;
    logic [AW-1:0]   read_addr;
    logic [7:0]      x_inc;
    logic [5:0]      y_inc;
    logic            out_free;
    logic            go_down;
    logic            emit;

    assign cur_addr  = AW'(r_cur_y * COLUMNS) + AW'(r_cur_x);
    assign read_addr = AW'(i_cmd.row * COLUMNS) + AW'(i_cmd.col);
    assign x_inc     = 8'(r_cur_x) + 8'd1;
    assign y_inc     = 6'(r_cur_y) + 6'd1;
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_fg        = r_fg;
        n_bg        = r_bg;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_waddr     = r_waddr;
        n_scr_flag  = r_scr_flag;
        n_cell_flag = r_cell_flag;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        go_down     = 1'b0;
        emit        = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = cur_addr;
        mem_wdata   = {r_bg, r_fg, i_cmd.data};
        mem_re      = 1'b0;
        mem_raddr   = read_addr;

        // The copy walk writes each cell in the cycle after it reads it.
        if (r_pend) begin
            mem_we    = 1'b1;
            mem_waddr = r_waddr;
            mem_wdata = r_rdata;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty && out_free) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        tmcw_pkg::OP_CHAR: begin
                            mem_we = 1'b1;
                            if (x_inc == COL_LIM) begin
                                n_cur_x = 7'd0;
                                go_down = 1'b1;
                            end else begin
                                n_cur_x = x_inc[6:0];
                                emit    = 1'b1;
                            end
                        end
                        tmcw_pkg::OP_LF: begin
                            n_cur_x = 7'd0;
                            go_down = 1'b1;
                        end
                        tmcw_pkg::OP_CR: begin
                            n_cur_x = 7'd0;
                            emit    = 1'b1;
                        end
                        tmcw_pkg::OP_FG: begin
                            n_fg = i_cmd.colour;
                            emit = 1'b1;
                        end
                        tmcw_pkg::OP_BG: begin
                            n_bg = i_cmd.colour;
                            emit = 1'b1;
                        end
                        tmcw_pkg::OP_READ: begin
                            mem_re      = 1'b1;
                            n_cell_flag = 1'b1;
                            n_scr_flag  = 1'b0;
                            n_state     = S_DONE;
                        end
                        tmcw_pkg::OP_CLEAR: begin
                            n_cnt       = '0;
                            n_cell_flag = 1'b0;
                            n_scr_flag  = 1'b0;
                            n_state     = S_CLEAR;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                    if (go_down) begin
                        if (y_inc == ROW_LIM) begin
                            n_cur_y = LAST_ROW;
                            n_cnt   = '0;
                            n_state = S_COPY;
                        end else begin
                            n_cur_y = y_inc[4:0];
                            emit    = 1'b1;
                        end
                    end
                    if (emit) begin
                        n_out_valid      = 1'b1;
                        n_out.cursor_col = n_cur_x;
                        n_out.cursor_row = n_cur_y;
                        n_out.scrolled   = 1'b0;
                        n_out.cell_char  = 8'd0;
                        n_out.cell_fg    = 4'd0;
                        n_out.cell_bg    = 4'd0;
                    end
                end
            end
            S_COPY: begin
                mem_re    = 1'b1;
                mem_raddr = r_cnt + ROW_SPAN;
                n_pend    = 1'b1;
                n_waddr   = r_cnt;
                if (r_cnt == LAST_COPY) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                n_cnt   = FIRST_FILL;
                n_state = S_FILL;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = {r_bg, r_fg, tmcw_pkg::CH_SPACE};
                if (r_cnt == LAST_CELL) begin
                    n_cell_flag = 1'b0;
                    n_scr_flag  = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = {tmcw_pkg::CLR_BG, tmcw_pkg::CLR_FG, tmcw_pkg::CH_NUL};
                if (r_cnt == LAST_CELL) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.cursor_col = r_cur_x;
                    n_out.cursor_row = r_cur_y;
                    n_out.scrolled   = r_scr_flag;
                    n_out.cell_char  = r_cell_flag ? r_rdata[7:0] : 8'd0;
                    n_out.cell_fg    = r_cell_flag ? r_rdata[11:8] : 4'd0;
                    n_out.cell_bg    = r_cell_flag ? r_rdata[15:12] : 4'd0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_x     <= 7'd0;
            r_cur_y     <= 5'd0;
            r_fg        <= tmcw_pkg::FG_RESET;
            r_bg        <= tmcw_pkg::BG_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_scr_flag  <= 1'b0;
            r_cell_flag <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_fg        <= n_fg;
            r_bg        <= n_bg;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_scr_flag  <= n_scr_flag;
            r_cell_flag <= n_cell_flag;
        end
        r_waddr <= n_waddr;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cells[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_cells[mem_raddr];
        end
    end

    `TMCW_ASSERT_SAME(a_cursor_col_range, 1'b1, 8'(r_cur_x) < COL_LIM, "cursor column out of range")
    `TMCW_ASSERT_SAME(a_cursor_row_range, 1'b1, 6'(r_cur_y) < ROW_LIM, "cursor row out of range")
    `TMCW_ASSERT_SAME(a_pop_when_idle, o_pop, (r_state == S_IDLE) && !i_cmd_empty, "pop outside idle")
    `TMCW_ASSERT_SAME(a_scroll_last_row, r_out_valid && r_out.scrolled, r_out.cursor_row == LAST_ROW, "scroll left cursor off the last row")
    `TMCW_ASSERT_NEXT(a_drain_to_fill, r_state == S_DRAIN, (r_state == S_FILL) && !r_pend, "copy drain did not hand over to fill")

endmodule
`default_nettype wire

FILE: src/text_mode_console_writer_core.sv
// Top level of the text-mode console writer: front end, command queue, back end.
//
// The input channel (i_in_valid / o_in_ready / i_in_data) takes one beat per
// console operation: write a byte, apply an ANSI colour code, read a cell or
// clear the screen. The output channel (o_out_valid / i_out_ready / o_out_data)
// returns exactly one beat per input beat, in order, carrying the cursor after
// the operation, a scrolled flag and, for reads, the cell contents.
// An accepted beat is classified at once and lands in a four-deep queue, so
// the input side keeps taking beats while the back end works or waits.
// A scroll walks the store once through its single read and write port, and a
// clear writes every cell. Simple operations sustain one beat per cycle while
// the receiver holds i_out_ready high. Reset clears the cursor to the top left
// corner, sets light gray on black and empties the queue; the cell store is not
// swept, so cells hold garbage until written or cleared.
// When the receiver stalls, the result beat holds in the output register,
// the back end stops at its next result and the queue fills, after which
// o_in_ready drops until space frees up.
`timescale 1ns / 1ps
`default_nettype none
module text_mode_console_writer_core #(
    parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tmcw_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tmcw_pkg::t_out o_out_data
);

    tmcw_pkg::t_cmd front_cmd;
    tmcw_pkg::t_cmd queue_cmd;
    logic           queue_full;
    logic           queue_empty;
    logic           queue_push;
    logic           queue_pop;

    // A beat is accepted whenever the queue has a free slot.
    assign o_in_ready = !queue_full;
    assign queue_push = i_in_valid && !queue_full;

    tmcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_in  (i_in_data),
        .o_cmd (front_cmd)
    );

    tmcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (queue_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_cmd   (queue_cmd),
        .o_empty (queue_empty)
    );

    // The back end owns the cell store and the result register.
    tmcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_empty (queue_empty),
        .o_pop       (queue_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule
`default_nettype wire
